>>> rtl/core/bwtrc_pkg.sv
// Package for the BWT rank and cumulative-table block.
// Holds sizes, request codes and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package bwtrc_pkg;

  localparam int unsigned ALPHABET = 256;
  localparam int unsigned MAX_LEN  = 65536;

  localparam int unsigned REQ_W  = 2;
  localparam int unsigned SYM_W  = 8;
  localparam int unsigned VAL_W  = 17;
  localparam int unsigned ADDR_W = $clog2(ALPHABET);
  localparam int unsigned IDX_W  = $clog2(ALPHABET + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_LEN + 1);
  // running sum is clamped at MAX_LEN + 1 so "above MAX_LEN" stays visible
  localparam int unsigned SUM_W  = $clog2(MAX_LEN + 2);

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  typedef struct packed {
    logic load;      // latch the incoming request, reset walk state
    logic rd_in;     // read counter at the incoming symbol
    logic walk;      // step the query walk
    logic out_load;  // finish: commit writes/clear, fill output register
  } cmd_t;

  typedef struct packed {
    logic walk_busy;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/bwt_rank_and_cumulative_tables.sv
// BWT inversion tables: per-symbol occurrence counters and cumulative counts.
// Top level; instantiates bwtrc_ctrl and bwtrc_dp, uses bwtrc_pkg.
//
// Input stream (s_axis): tuser carries the request kind (append, query,
// clear), tdata the byte symbol. Output stream (m_axis): tdata carries the
// 17-bit value, tuser the overflow flag. Every request gives one result.
// Requests are handled one at a time; s_axis_tready is high while the block
// waits for a request, also while a result sits unclaimed in the output
// register.
// Steps from acceptance to result valid:
//   append: counter read at acceptance, then write-back and output load.
//   clear: all valid bits drop at once; unused code: output load only.
//   query: a walk over the counters below the symbol, one counter read per cycle
//   through the memory read port, then the output load.
// A new request is taken in the cycle after each result load.
// Reset empties the output register and marks every counter zero at once;
// no clearing pass is needed. When m_axis_tready is low, the result holds and
// the next transaction is taken but its completion waits for the output
// register to free up.
`default_nettype none

module bwt_rank_and_cumulative_tables (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
  input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [16:0] value, [23:17] zero
  output logic [0:0]       m_axis_tuser    // [0] overflow
);
  import bwtrc_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [VAL_W-1:0] out_value;
  logic             out_ovf;

  bwtrc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .req_i         (s_axis_tuser),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  bwtrc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (s_axis_tuser),
    .sym_i       (s_axis_tdata[SYM_W-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_value_o (out_value),
    .out_ovf_o   (out_ovf)
  );

  assign m_axis_tdata = {(OUT_DATA_W - VAL_W)'(0), out_value};
  assign m_axis_tuser = out_ovf;

endmodule

`default_nettype wire

>>> rtl/core/bwtrc_ctrl.sv
// Controller for the BWT rank and cumulative-table block.
// Sequences append, query walk and clear; depends on bwtrc_pkg.
`default_nettype none

module bwtrc_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic [bwtrc_pkg::REQ_W-1:0] req_i,
  input  wire bwtrc_pkg::sts_t           sts_i,
  output bwtrc_pkg::cmd_t                cmd_o
);
  import bwtrc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          if (req_i == REQ_APPEND) begin
            cmd_o.rd_in = 1'b1;
            state_d     = S_FIN;
          end else if (req_i == REQ_QUERY) begin
            state_d = S_WALK;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (!sts_i.walk_busy) state_d = S_FIN;
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

>>> rtl/core/bwtrc_dp.sv
// Datapath for the BWT rank and cumulative-table block: counter memory with
// valid bits, query accumulator and output register. Depends on bwtrc_pkg.
`default_nettype none

module bwtrc_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [bwtrc_pkg::REQ_W-1:0] req_i,
  input  wire logic [bwtrc_pkg::SYM_W-1:0] sym_i,
  input  wire bwtrc_pkg::cmd_t             cmd_i,
  output bwtrc_pkg::sts_t                  sts_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [bwtrc_pkg::VAL_W-1:0]      out_value_o,
  output logic                             out_ovf_o
);
  import bwtrc_pkg::*;

  logic [CNT_W-1:0]    mem [ALPHABET];
  logic [ALPHABET-1:0] valid_q;

  logic [REQ_W-1:0]  req_q;
  logic [SYM_W-1:0]  sym_q;
  logic [IDX_W-1:0]  idx_q;
  logic              pend_q;
  logic [SUM_W-1:0]  sum_q;
  logic              ovf_q;
  logic [CNT_W-1:0]  rd_mem_q;
  logic              rd_vld_q;
  logic              out_vld_q;
  logic [VAL_W-1:0]  out_val_q;
  logic              out_ovf_q;

  logic [IDX_W-1:0]  limit;
  logic              walk_done;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_cnt;
  logic              cnt_sat;
  logic              sym_ok;
  logic              wr_en;
  logic              clr_all;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_nxt;
  logic              sum_over;
  logic [VAL_W-1:0]  res_val;
  logic              res_ovf;

  // symbols at or above the alphabet size count every entry
  assign sym_ok    = {1'b0, sym_q} < (SYM_W+1)'(ALPHABET);
  assign limit     = sym_ok ? IDX_W'(sym_q) : IDX_W'(ALPHABET);
  assign walk_done = (idx_q == limit);

  assign rd_en   = cmd_i.rd_in || (cmd_i.walk && !walk_done);
  assign rd_addr = cmd_i.rd_in ? sym_i[ADDR_W-1:0] : idx_q[ADDR_W-1:0];
  assign rd_cnt  = rd_vld_q ? rd_mem_q : '0;
  assign cnt_sat = rd_cnt >= CNT_W'(MAX_LEN);

  assign wr_en   = cmd_i.out_load && (req_q == REQ_APPEND) && sym_ok && !cnt_sat;
  assign clr_all = cmd_i.out_load && (req_q == REQ_CLEAR);

  assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(rd_cnt);
  assign sum_nxt = (sum_add > (SUM_W+1)'(MAX_LEN + 1)) ? SUM_W'(MAX_LEN + 1)
                                                       : sum_add[SUM_W-1:0];
  assign sum_over = sum_q > SUM_W'(MAX_LEN);

  always_comb begin
    res_val = '0;
    res_ovf = 1'b0;
    unique case (req_q)
      REQ_APPEND: begin
        if (sym_ok) begin
          res_val = cnt_sat ? VAL_W'(MAX_LEN) : VAL_W'(rd_cnt);
          res_ovf = cnt_sat;
        end
      end
      REQ_QUERY: begin
        res_val = sum_over ? VAL_W'(MAX_LEN) : VAL_W'(sum_q);
        res_ovf = ovf_q || sum_over;
      end
      default: begin
        res_val = '0;
        res_ovf = 1'b0;
      end
    endcase
  end

  assign sts_o.walk_busy = !walk_done || pend_q;
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  // counter memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[sym_q[ADDR_W-1:0]] <= rd_cnt + CNT_W'(1);
    if (rd_en) begin
      rd_mem_q <= mem[rd_addr];
      rd_vld_q <= valid_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_all) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[sym_q[ADDR_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.load) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.walk) begin
      pend_q <= !walk_done;
      if (!walk_done) idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
      sym_q <= sym_i;
      sum_q <= '0;
      ovf_q <= 1'b0;
    end else if (pend_q) begin
      sum_q <= sum_nxt;
      ovf_q <= ovf_q || cnt_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_val_q <= res_val;
      out_ovf_q <= res_ovf;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_value_o = out_val_q;
  assign out_ovf_o   = out_ovf_q;

endmodule

`default_nettype wire

>>> rtl/core/bwtrc_checker.sv
// Port-level checks for bwt_rank_and_cumulative_tables, bound to the top level.
// Depends on bwtrc_pkg.
`default_nettype none

module bwtrc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [0:0]  m_axis_tuser
);
  import bwtrc_pkg::*;

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[VAL_W-1:0] <= VAL_W'(MAX_LEN))
    else $error("value above saturation limit");

  // saturation always shows up as the clamped value
  a_ovf_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[VAL_W-1:0] == VAL_W'(MAX_LEN))
    else $error("overflow without clamped value");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:VAL_W] == '0)
    else $error("nonzero padding in result");

endmodule

bind bwt_rank_and_cumulative_tables bwtrc_checker u_bwtrc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> verif/testbench.sv
// Testbench for bwt_rank_and_cumulative_tables: random and directed append, query
// and clear traffic with its own counter-table predictor and scoreboard.
// Depends on bwtrc_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module testbench;
  import bwtrc_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned SEG_ITEMS    = 50;
  localparam int unsigned IDLE_LIMIT   = 4000;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct {
    logic [REQ_W-1:0] kind;
    logic [SYM_W-1:0] sym;
    int unsigned      hold;  // idle cycles before this transaction
  } request_t;

  typedef struct {
    logic [VAL_W-1:0] value;
    logic             ovf;
  } lf_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] symbol
  logic [REQ_W-1:0]      s_axis_tuser = '0;   // [1:0] req_type
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // [16:0] value, [23:17] zero
  logic [0:0]            m_axis_tuser;        // [0] overflow

  request_t    req_queue[$];
  lf_result_t  exp_results[$];
  logic [VAL_W-1:0] sym_count [ALPHABET] = '{default: '0};
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          quiet = 1'b0;

  bwt_rank_and_cumulative_tables i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial forever #2 clk_i = ~clk_i;

  // mostly short, now and then long
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Rank / C-table predictor; updates the counter table like the block does.
  function automatic lf_result_t lf_lookup(logic [REQ_W-1:0] kind, logic [SYM_W-1:0] sym);
    lf_result_t  r;
    int unsigned sum;
    r.value = '0;
    r.ovf   = 1'b0;
    sum     = 0;
    case (kind)
      REQ_APPEND: begin
        if (sym_count[sym] >= MAX_LEN) begin
          r.value = VAL_W'(MAX_LEN);
          r.ovf   = 1'b1;
        end else begin
          r.value        = sym_count[sym];
          sym_count[sym] = sym_count[sym] + 1'b1;
        end
      end
      REQ_QUERY: begin
        for (int i = 0; i < int'(sym); i++) begin
          if (sym_count[i] >= MAX_LEN) r.ovf = 1'b1;
          sum += sym_count[i];
        end
        if (sum > MAX_LEN) r.ovf = 1'b1;
        if (sum >= MAX_LEN) sum = MAX_LEN;
        r.value = VAL_W'(sum);
      end
      REQ_CLEAR: begin
        foreach (sym_count[i]) sym_count[i] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_req(logic [REQ_W-1:0] kind, logic [SYM_W-1:0] sym, int unsigned hold);
    request_t q;
    q.kind = kind;
    q.sym  = sym;
    q.hold = hold;
    req_queue.insert(req_queue.size(), q);
  endtask

  // Driver: one transaction per slot, predicted on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    request_t q;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        exp_results.insert(exp_results.size(),
                           lf_lookup(s_axis_tuser, s_axis_tdata[SYM_W-1:0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (req_queue.size() != 0 && req_queue[0].hold != 0) begin
          req_queue[0].hold = req_queue[0].hold - 1;
          s_axis_tvalid <= 1'b0;
        end else if (req_queue.size() != 0) begin
          q = req_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= q.sym;
          s_axis_tuser  <= q.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random backpressure and in-order compare.
  always @(posedge clk_i or negedge rst_ni) begin
    lf_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result value=%0d overflow=%0d", $realtime,
                     m_axis_tdata[VAL_W-1:0], m_axis_tuser);
          mismatches++;
        end else begin
          want = exp_results.pop_front();
          if (m_axis_tdata !== {{(OUT_DATA_W-VAL_W){1'b0}}, want.value} ||
              m_axis_tuser !== want.ovf) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected value=%0d overflow=%0d, got tdata=%h overflow=%b",
                       $realtime, want.value, want.ovf, m_axis_tdata, m_axis_tuser);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 499) == 0) quiet = !quiet;
      if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) stall_left = idle_len();
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $realtime, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [REQ_W-1:0] kind;
    logic [SYM_W-1:0] sym;
    int unsigned      focus;
    int unsigned      pick;
    bit               calm;

    // empty table, symbol extremes, unused code, clear
    add_req(REQ_QUERY, 8'd0, 0);
    add_req(REQ_QUERY, 8'd255, 2);
    add_req(REQ_APPEND, 8'd0, 0);
    add_req(REQ_APPEND, 8'd0, 0);
    add_req(REQ_APPEND, 8'd255, 1);
    add_req(REQ_APPEND, 8'd128, 0);
    add_req(REQ_APPEND, 8'd255, 0);
    add_req(REQ_QUERY, 8'd1, 0);
    add_req(REQ_QUERY, 8'd128, 3);
    add_req(REQ_QUERY, 8'd129, 0);
    add_req(REQ_QUERY, 8'd255, 0);
    add_req(REQ_UNUSED, 8'd255, 0);
    add_req(REQ_UNUSED, 8'd0, 0);
    add_req(REQ_QUERY, 8'd255, 0);
    add_req(REQ_CLEAR, 8'd77, 0);
    add_req(REQ_QUERY, 8'd255, 0);
    add_req(REQ_APPEND, 8'd255, 0);
    add_req(REQ_CLEAR, 8'd0, 0);

    // random text segments, each around a focus range of symbols
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEG_ITEMS == 0) begin
        focus = $urandom_range(0, 247);
        calm  = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 60) kind = REQ_APPEND;
      else if (pick < 92) kind = REQ_QUERY;
      else if (pick < 96) kind = REQ_CLEAR;
      else kind = REQ_UNUSED;
      if ($urandom_range(0, 1) == 0) sym = SYM_W'($urandom_range(0, 255));
      else sym = SYM_W'(focus + $urandom_range(0, 8));
      add_req(kind, sym, (calm || $urandom_range(0, 1) == 0) ? 0 : idle_len());
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_queue.size() != 0 || s_axis_tvalid || exp_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
